/* rtl/core/set_assoc_lru_replacement_macros.svh */
// ----------------------------------------------------------------------------
// LRU replacement assertion macros
// Shorthand for clocked assertions on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_REPLACEMENT_MACROS_SVH
`define SET_ASSOC_LRU_REPLACEMENT_MACROS_SVH

// same-cycle implication
`define SAR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SAR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sar_pkg.sv */
// ----------------------------------------------------------------------------
// LRU replacement package
// Field widths, default geometry and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package sar_pkg;

  localparam int unsigned SET_IDX_W = 6;
  localparam int unsigned WAY_IN_W  = 2;
  localparam int unsigned VICTIM_W  = 2;

  localparam int unsigned WAYS_DEF  = 4;
  localparam int unsigned SETS_DEF  = 64;

  typedef enum logic [0:0] {
    KIND_TOUCH   = 1'b0,
    KIND_REPLACE = 1'b1
  } sar_kind_e;

  typedef struct packed {
    sar_kind_e             kind;
    logic [WAY_IN_W-1:0]   way;
  } sar_req_t;

endpackage

`default_nettype wire

/* rtl/core/sar_in_if.sv */
// ----------------------------------------------------------------------------
// LRU request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sar_in_if import sar_pkg::*; ();

  logic                 valid;
  logic                 ready;
  sar_kind_e            kind;
  logic [SET_IDX_W-1:0] set_index;
  logic [WAY_IN_W-1:0]  way;

  modport source (output valid, output kind, output set_index, output way, input ready);
  modport sink   (input valid, input kind, input set_index, input way, output ready);

endinterface

`default_nettype wire

/* rtl/core/sar_out_if.sv */
// ----------------------------------------------------------------------------
// LRU victim channel
// Valid/ready channel carrying one victim word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sar_out_if import sar_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [VICTIM_W-1:0] victim_way;

  modport source (output valid, output victim_way, input ready);
  modport sink   (input valid, input victim_way, output ready);

endinterface

`default_nettype wire

/* rtl/core/sar_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sar_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/core/sar_reorder.sv */
// ----------------------------------------------------------------------------
// LRU row reorder
// Moves the chosen way of one recency row to the most recent end.
// ----------------------------------------------------------------------------
`default_nettype none

module sar_reorder import sar_pkg::*; #(
  parameter int unsigned WAYS = WAYS_DEF,
  localparam int unsigned WAY_W = $clog2(WAYS),
  localparam int unsigned CMP_W = (WAY_W > WAY_IN_W) ? WAY_W : WAY_IN_W
) (
  input  wire logic [WAYS-1:0][WAY_W-1:0] row_i,
  input  wire sar_req_t                   req_i,
  output logic      [WAYS-1:0][WAY_W-1:0] row_o,
  output logic      [VICTIM_W-1:0]        victim_o
);

  logic [WAYS-1:0]  match;
  logic [WAY_W-1:0] pos;
  logic             mv;
  logic [CMP_W-1:0] front_ext;

  // a touch of a way beyond the set matches nothing, so the row holds
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      match[i] = (CMP_W'(row_i[i]) == CMP_W'(req_i.way));
    end
  end

  always_comb begin
    pos = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        pos = WAY_W'(i);
      end
    end
    if (req_i.kind == KIND_REPLACE) begin
      pos = '0;
    end
    mv = (req_i.kind == KIND_REPLACE) || (|match);
  end

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      if (!mv || (WAY_W'(i) < pos)) begin
        row_o[i] = row_i[i];
      end else if (i == WAYS - 1) begin
        row_o[i] = row_i[pos];
      end else begin
        row_o[i] = row_i[i + 1];
      end
    end
  end

  assign front_ext = CMP_W'(row_i[0]);
  assign victim_o  = front_ext[VICTIM_W-1:0];

endmodule

`default_nettype wire

/* rtl/core/set_assoc_lru_replacement.sv */
// ----------------------------------------------------------------------------
// True-LRU replacement state
// Per-set recency order of way numbers held in one synchronous RAM row per
// set; read, reordered and written back with one-deep forwarding.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all SETS rows, writing the
// order 0..WAYS-1 into every row, and holds ready low meanwhile. The RAM read
// of a request word's row is issued at the edge that accepts it; in the next
// cycle the row is reordered and written back, and a replace word's victim is
// loaded into the output register at the end of that cycle, from which the
// victim word is offered on the output channel. Words are taken every
// cycle, except that a replace word blocks acceptance for the following cycle
// while its victim claims the output register, and no word is taken while a
// victim waits in that register against a stalled receiver. Back-to-back
// accesses to the same set are served from a forwarding register, since the
// RAM write of one word lands in the cycle its successor reads. Set indices
// wrap modulo SETS; a touch of a way not below WAYS leaves the order as is.
// ----------------------------------------------------------------------------
`default_nettype none
`include "set_assoc_lru_replacement_macros.svh"

module set_assoc_lru_replacement import sar_pkg::*; #(
  parameter int unsigned WAYS = WAYS_DEF,
  parameter int unsigned SETS = SETS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sar_in_if.sink    in_i,
  sar_out_if.source out_o
);

  localparam int unsigned WAY_W = $clog2(WAYS);
  localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned ROW_W = WAYS * WAY_W;
  localparam int unsigned IDX_N = 2 ** SET_IDX_W;

  logic [SET_W-1:0] idx_tbl [IDX_N];

  for (genvar v = 0; v < IDX_N; v++) begin : g_idx
    localparam int unsigned R = v % SETS;
    assign idx_tbl[v] = SET_W'(R);
  end

  logic                        accept;
  logic [SET_W-1:0]            in_idx;
  logic [WAYS-1:0][WAY_W-1:0]  ident_row;
  logic [WAYS-1:0][WAY_W-1:0]  cur_row;
  logic [WAYS-1:0][WAY_W-1:0]  new_row;
  logic [ROW_W-1:0]            rdata;
  logic [VICTIM_W-1:0]         victim;

  logic                        clr_q, clr_d;
  logic [SET_W-1:0]            clr_cnt_q, clr_cnt_d;
  logic                        s1_valid_q, s1_valid_d;
  sar_req_t                    s1_req_q;
  logic [SET_W-1:0]            s1_idx_q;
  logic                        fwd_hit_q, fwd_hit_d;
  logic [WAYS-1:0][WAY_W-1:0]  fwd_row_q;
  logic                        out_valid_q, out_valid_d;
  logic [VICTIM_W-1:0]         out_victim_q;

  logic                        ram_we;
  logic [SET_W-1:0]            ram_waddr;
  logic [ROW_W-1:0]            ram_wdata;

  logic                        s1_repl;

  assign s1_repl = s1_valid_q && (s1_req_q.kind == KIND_REPLACE);

  assign in_i.ready = !clr_q && (!out_valid_q || out_o.ready) && !s1_repl;
  assign accept     = in_i.valid && in_i.ready;
  assign in_idx     = idx_tbl[in_i.set_index];

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      ident_row[i] = WAY_W'(i);
    end
  end

  // clearing pass writes the reset order, otherwise stage one writes back
  assign ram_we    = clr_q || s1_valid_q;
  assign ram_waddr = clr_q ? clr_cnt_q : s1_idx_q;
  assign ram_wdata = clr_q ? ROW_W'(ident_row) : ROW_W'(new_row);

  sar_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (in_idx),
    .rdata_o (rdata)
  );

  assign cur_row = fwd_hit_q ? fwd_row_q : rdata;

  sar_reorder #(
    .WAYS (WAYS)
  ) u_reorder (
    .row_i    (cur_row),
    .req_i    (s1_req_q),
    .row_o    (new_row),
    .victim_o (victim)
  );

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == SET_W'(SETS - 1)) begin
        clr_d = 1'b0;
      end
    end
    s1_valid_d  = accept;
    fwd_hit_d   = accept && s1_valid_q && (in_idx == s1_idx_q);
    out_valid_d = out_valid_q;
    if (s1_repl) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      clr_cnt_q   <= clr_cnt_d;
      s1_valid_q  <= s1_valid_d;
      fwd_hit_q   <= fwd_hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q.kind <= in_i.kind;
      s1_req_q.way  <= in_i.way;
      s1_idx_q      <= in_idx;
    end
    fwd_row_q <= new_row;
    if (s1_repl) begin
      out_victim_q <= victim;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.victim_way = out_victim_q;

  `SAR_ASSERT_IMP(a_repl_slot_free, s1_repl, !out_valid_q,
    "replace in stage one found output register occupied")
  `SAR_ASSERT_IMP(a_no_work_in_clear, clr_q, !s1_valid_q,
    "word in flight during clearing pass")
  `SAR_ASSERT_IMP(a_fwd_same_set, s1_valid_q && fwd_hit_q, s1_idx_q == $past(s1_idx_q),
    "forwarded row belongs to another set")
  `SAR_ASSERT_NXT(a_fwd_after_word, fwd_hit_d, s1_valid_q,
    "forwarding armed without a following word")

endmodule

`default_nettype wire

/* verif/sar_lru_checker.sv */
// ----------------------------------------------------------------------------
// LRU replacement checker
// Watches the request and victim channels. Keeps its own per-set recency
// order, predicts each victim word and compares it with the word that leaves
// the block.
// ----------------------------------------------------------------------------
module sar_lru_checker import sar_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sar_in_if           req_mon_i,
  sar_out_if          vic_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned WAYS = WAYS_DEF;
  localparam int unsigned SETS = SETS_DEF;

  logic [WAY_IN_W-1:0] lru_order [SETS][WAYS];
  logic [VICTIM_W-1:0] victim_q [$];

  // front of a row is least recent, back is most recent
  task automatic apply_access(input sar_kind_e kind, input logic [SET_IDX_W-1:0] set_index,
                              input logic [WAY_IN_W-1:0] way);
    int unsigned         row;
    int                  pos;
    logic [WAY_IN_W-1:0] used;
    row = set_index % SETS;
    pos = -1;
    if (kind == KIND_REPLACE) begin
      pos = 0;
      victim_q.push_back(VICTIM_W'(lru_order[row][0]));
    end else if (way < WAYS) begin
      for (int i = 0; i < WAYS; i++)
        if (pos < 0 && lru_order[row][i] == way) pos = i;
    end
    if (pos >= 0) begin
      used = lru_order[row][pos];
      for (int i = pos; i < WAYS - 1; i++) lru_order[row][i] = lru_order[row][i + 1];
      lru_order[row][WAYS - 1] = used;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SETS; s++)
        for (int w = 0; w < WAYS; w++) lru_order[s][w] = WAY_IN_W'(w);
      victim_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (vic_mon_i.valid && vic_mon_i.ready) begin
        if (victim_q.size() == 0) begin
          $error("victim_way: unexpected word, actual %0d", vic_mon_i.victim_way);
          fail_count_o++;
        end else begin
          if (vic_mon_i.victim_way !== victim_q[0]) begin
            $error("victim_way: expected %0d, actual %0d", victim_q[0], vic_mon_i.victim_way);
            fail_count_o++;
          end
          void'(victim_q.pop_front());
        end
      end
      if (req_mon_i.valid && req_mon_i.ready)
        apply_access(req_mon_i.kind, req_mon_i.set_index, req_mon_i.way);
      pending_o = victim_q.size();
    end
  end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// LRU replacement testbench
// Drives directed and random touch/replace words in bursts against a
// stalling receiver; the checker predicts and compares every victim word.
// ----------------------------------------------------------------------------
module tb;
  import sar_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1000;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  typedef struct packed {
    sar_kind_e            kind;
    logic [SET_IDX_W-1:0] set_index;
    logic [WAY_IN_W-1:0]  way;
  } lru_word_t;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles;
  int unsigned burst_left;
  int unsigned stall_mode;
  int unsigned stall_left;

  sar_in_if  req_ch ();
  sar_out_if vic_ch ();

  set_assoc_lru_replacement dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (vic_ch)
  );

  sar_lru_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon_i    (req_ch),
    .vic_mon_i    (vic_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: runs of always-ready, light, heavy and long stalls
  initial begin
    vic_ch.ready = 1'b0;
    stall_mode   = 0;
    stall_left   = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 96);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: vic_ch.ready <= 1'b1;
        1: vic_ch.ready <= ($urandom_range(0, 3) != 0);
        2: vic_ch.ready <= ($urandom_range(0, 3) == 0);
        default: vic_ch.ready <= (stall_left % 12 == 0);
      endcase
    end
  end

  // ready is sampled mid-cycle, where it holds the value seen by the next edge
  task automatic send_word(input lru_word_t w);
    logic took;
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= w.kind;
    req_ch.set_index <= w.set_index;
    req_ch.way       <= w.way;
    do begin
      @(negedge clk_i);
      took = req_ch.ready;
      @(posedge clk_i);
    end while (!took);
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    lru_word_t                 directed [$];
    lru_word_t                 w;
    logic [SET_IDX_W-1:0]      hot_sets [4];

    rst_ni           = 1'b0;
    cycles           = 0;
    burst_left       = 0;
    req_ch.valid     = 1'b0;
    req_ch.kind      = KIND_TOUCH;
    req_ch.set_index = '0;
    req_ch.way       = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset order, back-to-back same set, touches of every way, both set extremes
    directed = '{
      '{KIND_REPLACE, 6'd0,  2'd0}, '{KIND_REPLACE, 6'd0,  2'd3},
      '{KIND_TOUCH,   6'd0,  2'd2}, '{KIND_REPLACE, 6'd0,  2'd1},
      '{KIND_REPLACE, 6'd0,  2'd0}, '{KIND_TOUCH,   6'd0,  2'd0},
      '{KIND_TOUCH,   6'd0,  2'd1}, '{KIND_REPLACE, 6'd0,  2'd2},
      '{KIND_TOUCH,   6'd63, 2'd3}, '{KIND_TOUCH,   6'd63, 2'd0},
      '{KIND_REPLACE, 6'd63, 2'd0}, '{KIND_REPLACE, 6'd63, 2'd3},
      '{KIND_TOUCH,   6'd63, 2'd1}, '{KIND_REPLACE, 6'd63, 2'd1},
      '{KIND_REPLACE, 6'd63, 2'd2}, '{KIND_TOUCH,   6'd42, 2'd3},
      '{KIND_TOUCH,   6'd21, 2'd2}, '{KIND_REPLACE, 6'd42, 2'd0},
      '{KIND_REPLACE, 6'd21, 2'd3}, '{KIND_TOUCH,   6'd0,  2'd3},
      '{KIND_REPLACE, 6'd0,  2'd1}
    };
    foreach (directed[i]) send_word(directed[i]);

    foreach (hot_sets[i]) hot_sets[i] = SET_IDX_W'($urandom_range(0, 63));
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2) begin
        req_ch.valid <= 1'b0;
        wait_drained();
      end
      w.kind      = sar_kind_e'($urandom_range(0, 1));
      w.set_index = ($urandom_range(0, 9) < 7) ? hot_sets[$urandom_range(0, 3)]
                                               : SET_IDX_W'($urandom_range(0, 63));
      w.way       = WAY_IN_W'($urandom_range(0, 3));
      send_word(w);
    end
    req_ch.valid <= 1'b0;

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/sar_pkg.sv
rtl/core/sar_in_if.sv
rtl/core/sar_out_if.sv
rtl/core/sar_ram.sv
rtl/core/sar_reorder.sv
rtl/core/set_assoc_lru_replacement.sv
verif/sar_lru_checker.sv
verif/tb.sv
